FILE: hdl/dba_pkg.sv
// Shared types and constants for the downward bump allocator.
// Depends on nothing; used by the interfaces and every hdl module but dba_fifo.
package dba_pkg;

  // Default address width of the pointer and region registers
  localparam int unsigned ADDR_WIDTH_DEF = 32;

  // Field widths fixed by the request and response formats
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ALIGN_W = 5;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CFG_IDX_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BEGIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 8'd1;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESTORE = 2'd1,
    OP_RESET   = 2'd2
  } op_e;

  // Classified request as it travels from front to back (product kept apart,
  // its width follows the address width)
  typedef struct packed {
    op_e                op;
    logic               ovf;
    logic [ALIGN_W-1:0] align_log2;
    logic [DATA_W-1:0]  mark_value;
  } cmd_t;

endpackage

FILE: hdl/dba_ifs.sv
// Channel interfaces of the downward bump allocator: request, response, config.
// Depends on dba_pkg for field widths.
interface dba_req_if;
  logic                          valid;
  logic                          ready;
  logic [dba_pkg::OP_W-1:0]      op;
  logic [dba_pkg::DATA_W-1:0]    item_count;
  logic [dba_pkg::DATA_W-1:0]    item_size;
  logic [dba_pkg::ALIGN_W-1:0]   align_log2;
  logic [dba_pkg::DATA_W-1:0]    mark_value;

  modport source (output valid, op, item_count, item_size, align_log2, mark_value,
                  input ready);
  modport sink   (input valid, op, item_count, item_size, align_log2, mark_value,
                  output ready);
endinterface

interface dba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [dba_pkg::DATA_W-1:0]  block_address;
  logic                        ok;
  logic [dba_pkg::DATA_W-1:0]  top_pointer;

  modport source (output valid, block_address, ok, top_pointer, input ready);
  modport sink   (input valid, block_address, ok, top_pointer, output ready);
endinterface

interface dba_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dba_pkg::CFG_IDX_W-1:0]  index;
  logic [dba_pkg::DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/dba_front.sv
// Front end: accepts requests, forms count * size, flags product overflow.
// Depends on dba_pkg and dba_req_if.
module dba_front #(
  parameter int unsigned ADDR_WIDTH = dba_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dba_req_if.sink               req,
  // classified word toward the queue
  output logic                  push_o,
  input  logic                  full_i,
  output dba_pkg::cmd_t         cmd_o,
  output logic [ADDR_WIDTH-1:0] total_o
);

  logic                               vld_q, vld_d;
  dba_pkg::op_e                       op_q;
  logic [2*dba_pkg::DATA_W-1:0]       prod_q;
  logic [dba_pkg::ALIGN_W-1:0]        alog_q;
  logic [dba_pkg::DATA_W-1:0]         mark_q;
  logic                               take;
  logic [2*dba_pkg::DATA_W-1:0]       prod_hi;

  // Stage register frees up when its word moves into the queue
  assign push_o    = vld_q && !full_i;
  assign req.ready = !vld_q || !full_i;
  assign take      = req.valid && req.ready;
  assign vld_d     = take ? 1'b1 : (push_o ? 1'b0 : vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // 32x32 multiply, registered before use
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q   <= dba_pkg::op_e'(req.op);
      prod_q <= (2*dba_pkg::DATA_W)'(req.item_count) * (2*dba_pkg::DATA_W)'(req.item_size);
      alog_q <= req.align_log2;
      mark_q <= req.mark_value;
    end
  end

  // Overflow: any product bit at or above the address width
  assign prod_hi = prod_q >> ADDR_WIDTH;

  always_comb begin
    cmd_o.op         = op_q;
    cmd_o.ovf        = |prod_hi;
    cmd_o.align_log2 = alog_q;
    cmd_o.mark_value = mark_q;
  end

  assign total_o = ADDR_WIDTH'(prod_q);

endmodule

FILE: hdl/dba_fifo.sv
// Two-entry queue between front and back ends.
// Depends on nothing beyond its width parameter.
module dba_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update
  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i  ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

FILE: hdl/dba_back.sv
// Back end: holds region registers and the top pointer, applies each word,
// and drives the response register. Depends on dba_pkg, dba_rsp_if, dba_cfg_if.
module dba_back #(
  parameter int unsigned ADDR_WIDTH = dba_pkg::ADDR_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dba_cfg_if.sink               cfg,
  dba_rsp_if.source             rsp,
  input  logic                  empty_i,
  output logic                  pop_o,
  input  dba_pkg::cmd_t         cmd_i,
  input  logic [ADDR_WIDTH-1:0] total_i
);

  logic [ADDR_WIDTH-1:0]       begin_q, end_q, top_q, top_d;
  logic                        ovld_q, ovld_d;
  logic [dba_pkg::DATA_W-1:0]  blk_q, blk_d, otop_q;
  logic                        ok_q, ok_d;
  logic [ADDR_WIDTH-1:0]       diff, pos;
  logic [63:0]                 amask;
  logic [63:0]                 mark_x, begin_x, end_x, top_x, pos_x, topd_x;
  logic [63:0]                 cfg_x;

  // Configuration writes, masked to the address width
  assign cfg.ready = 1'b1;
  assign cfg_x     = 64'(cfg.data);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_q <= '0;
      end_q   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        dba_pkg::CFG_REGION_BEGIN: begin_q <= ADDR_WIDTH'(cfg_x);
        dba_pkg::CFG_REGION_END:   end_q   <= ADDR_WIDTH'(cfg_x);
        default: ;
      endcase
    end
  end

  // Output register takes a new word whenever it is empty or being drained
  assign pop_o  = !empty_i && (!ovld_q || rsp.ready);
  assign ovld_d = pop_o ? 1'b1 : (rsp.ready ? 1'b0 : ovld_q);

  // Allocation path: subtract, align down, range check
  assign diff    = top_q - total_i;
  assign amask   = ~((64'd1 << cmd_i.align_log2) - 64'd1);
  assign pos     = diff & ADDR_WIDTH'(amask);
  assign mark_x  = 64'(cmd_i.mark_value);
  assign begin_x = 64'(begin_q);
  assign end_x   = 64'(end_q);
  assign top_x   = 64'(top_q);
  assign pos_x   = 64'(pos);

  always_comb begin
    top_d = top_q;
    blk_d = '0;
    ok_d  = 1'b0;
    case (cmd_i.op)
      dba_pkg::OP_ALLOC: begin
        if (!cmd_i.ovf && total_i <= top_q && pos >= begin_q) begin
          top_d = pos;
          blk_d = dba_pkg::DATA_W'(pos_x);
          ok_d  = 1'b1;
        end
      end
      dba_pkg::OP_RESTORE: begin
        if (mark_x >= begin_x && mark_x <= end_x) begin
          if (top_x <= mark_x) begin
            top_d = ADDR_WIDTH'(mark_x);
          end
          ok_d = 1'b1;
        end
      end
      dba_pkg::OP_RESET: begin
        top_d = end_q;
        ok_d  = 1'b1;
      end
      default: ;
    endcase
  end

  assign topd_x = 64'(top_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      ovld_q <= ovld_d;
      if (pop_o) begin
        top_q <= top_d;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      blk_q  <= blk_d;
      ok_q   <= ok_d;
      otop_q <= dba_pkg::DATA_W'(topd_x);
    end
  end

  assign rsp.valid         = ovld_q;
  assign rsp.block_address = blk_q;
  assign rsp.ok            = ok_q;
  assign rsp.top_pointer   = otop_q;

endmodule

FILE: hdl/downward_bump_allocator_core.sv
// Top level of the downward bump allocator: front end, queue, back end.
// Depends on dba_pkg, the channel interfaces, dba_front, dba_fifo, dba_back.
//
// Keeps a top pointer that moves down through [region_begin, region_end].
// Each request gives exactly one response, in order. Allocate subtracts
// item_count * item_size from the pointer and aligns the result down to
// 2^align_log2; it fails with no change on product overflow, on underflow,
// or when the result falls below region_begin. Restore moves the pointer up
// to a mark inside the region (a mark below the pointer is accepted and
// ignored); reset puts the pointer at region_end. The block takes one request
// per cycle while the response side is ready; each request passes through the
// multiply register, the two-entry queue and the response register. The
// pointer update (subtract, align, compare) is combinational in the back
// end and loops through the top pointer, so the rate is set by that stage.
// Configuration writes are always ready and do not move the pointer.
module downward_bump_allocator_core #(
  parameter int unsigned ADDR_WIDTH = dba_pkg::ADDR_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dba_req_if.sink   req_i,
  dba_rsp_if.source rsp_o,
  dba_cfg_if.sink   cfg_i
);

  localparam int unsigned QW = $bits(dba_pkg::cmd_t) + ADDR_WIDTH;

  logic                  push, full, pop, empty;
  dba_pkg::cmd_t         f_cmd, b_cmd;
  logic [ADDR_WIDTH-1:0] f_total, b_total;
  logic [QW-1:0]         q_wdata, q_rdata;

  dba_front #(.ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_i),
    .push_o  (push),
    .full_i  (full),
    .cmd_o   (f_cmd),
    .total_o (f_total)
  );

  assign q_wdata = {f_cmd, f_total};

  dba_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (q_rdata)
  );

  assign {b_cmd, b_total} = q_rdata;

  dba_back #(.ADDR_WIDTH(ADDR_WIDTH)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg     (cfg_i),
    .rsp     (rsp_o),
    .empty_i (empty),
    .pop_o   (pop),
    .cmd_i   (b_cmd),
    .total_i (b_total)
  );

endmodule

FILE: tb/downward_bump_allocator_core_checker.sv
`timescale 1ns / 100ps
// Response checker for the downward bump allocator: predicts each response word
// from accepted requests and config writes. Depends on dba_pkg and the channel interfaces.
module downward_bump_allocator_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  dba_req_if          req_i,
  dba_rsp_if          rsp_i,
  dba_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import dba_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] block_address;
    logic              ok;
    logic [DATA_W-1:0] top_pointer;
  } bump_word_t;

  // Shadow copies of the region registers and the top pointer
  logic [DATA_W-1:0] region_lo;
  logic [DATA_W-1:0] region_hi;
  logic [DATA_W-1:0] top_ptr;

  bump_word_t  expected_words[$];
  int unsigned failures;

  // Response word for one request, given the current pointer and region
  function automatic bump_word_t predict_bump(input logic [OP_W-1:0]    op,
                                              input logic [DATA_W-1:0]  count,
                                              input logic [DATA_W-1:0]  size,
                                              input logic [ALIGN_W-1:0] alog,
                                              input logic [DATA_W-1:0]  mark);
    logic [2*DATA_W-1:0] product;
    logic [DATA_W-1:0]   align_mask;
    logic [DATA_W-1:0]   pos;
    bump_word_t          w;
    w.block_address = '0;
    w.ok            = 1'b0;
    w.top_pointer   = top_ptr;
    case (op)
      OP_ALLOC: begin
        product    = {{DATA_W{1'b0}}, count} * {{DATA_W{1'b0}}, size};
        align_mask = (32'd1 << alog) - 32'd1;
        // fail on product overflow or when the product exceeds the pointer
        if (product[2*DATA_W-1:DATA_W] == '0 && product[DATA_W-1:0] <= top_ptr) begin
          pos = (top_ptr - product[DATA_W-1:0]) & ~align_mask;
          if (pos >= region_lo) begin
            w.block_address = pos;
            w.ok            = 1'b1;
            w.top_pointer   = pos;
          end
        end
      end
      OP_RESTORE: begin
        // mark must lie in the region; a mark below the pointer is a no-op
        if (mark >= region_lo && mark <= region_hi) begin
          w.ok = 1'b1;
          if (top_ptr <= mark) w.top_pointer = mark;
        end
      end
      OP_RESET: begin
        w.ok          = 1'b1;
        w.top_pointer = region_hi;
      end
      default: ;
    endcase
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bump_word_t seen;
    bump_word_t want;
    if (!rst_ni) begin
      region_lo = '0;
      region_hi = '0;
      top_ptr   = '0;
      failures  = 0;
      expected_words.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // compare a delivered word with the oldest expectation
      if (rsp_i.valid && rsp_i.ready) begin
        seen.block_address = rsp_i.block_address;
        seen.ok            = rsp_i.ok;
        seen.top_pointer   = rsp_i.top_pointer;
        if (expected_words.size() == 0) begin
          if (failures < 10)
            $display("%0t: unexpected response: addr %h ok %b top %h",
                     $realtime, seen.block_address, seen.ok, seen.top_pointer);
          failures++;
        end else begin
          want = expected_words.pop_front();
          if (seen.block_address !== want.block_address || seen.ok !== want.ok ||
              seen.top_pointer !== want.top_pointer) begin
            if (failures < 10)
              $display("%0t: mismatch: expected addr %h ok %b top %h, got addr %h ok %b top %h",
                       $realtime, want.block_address, want.ok, want.top_pointer,
                       seen.block_address, seen.ok, seen.top_pointer);
            failures++;
          end
        end
      end

      // predict the word for an accepted request
      if (req_i.valid && req_i.ready) begin
        want = predict_bump(req_i.op, req_i.item_count, req_i.item_size,
                            req_i.align_log2, req_i.mark_value);
        top_ptr = want.top_pointer;
        expected_words.push_back(want);
      end

      // register writes leave the pointer alone
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_REGION_BEGIN: region_lo = cfg_i.data;
          CFG_REGION_END:   region_hi = cfg_i.data;
          default: ;
        endcase
      end

      fail_count_o <= failures;
      pending_o    <= expected_words.size();
    end
  end

endmodule

FILE: tb/downward_bump_allocator_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the downward bump allocator: clock, reset, stimulus and verdict.
// Depends on dba_pkg, the channel interfaces, the core and its checker.
module downward_bump_allocator_core_tb;
  import dba_pkg::*;

  typedef enum int unsigned {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned RANDOM_PHASES   = 7;
  localparam int unsigned ITEMS_PER_PHASE = 145;
  localparam int unsigned DRAIN_CYCLES    = 8;

  logic clk_i;
  logic rst_ni;

  dba_req_if req_ch ();
  dba_rsp_if rsp_ch ();
  dba_cfg_if cfg_ch ();

  int unsigned fail_cnt;
  int unsigned pending_cnt;

  downward_bump_allocator_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  downward_bump_allocator_core_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_cnt),
    .pending_o    (pending_cnt)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Response side: stall pattern that switches mode every so often
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_ALWAYS: rsp_ch.ready <= 1'b1;
      RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      default:   rsp_ch.ready <= (rx_tick % 5 == 0);
    endcase
  end

  // Recent pointers seen on the response side, reused as marks.
  // Sampled mid-cycle so the value is settled for the coming edge.
  logic [DATA_W-1:0] saved_marks[$];

  always @(negedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      saved_marks.push_back(rsp_ch.top_pointer);
      if (saved_marks.size() > 16) void'(saved_marks.pop_front());
    end
  end

  // Watchdog on cycles with no word moving on any channel
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("downward_bump_allocator_core_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Request side: bursts of random length with random gaps in between
  int unsigned burst_left = 0;

  task automatic send_word(input logic [OP_W-1:0]    op,
                           input logic [DATA_W-1:0]  count,
                           input logic [DATA_W-1:0]  size,
                           input int unsigned        alog,
                           input logic [DATA_W-1:0]  mark);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.item_count <= count;
    req_ch.item_size  <= size;
    req_ch.align_log2 <= ALIGN_W'(alog);
    req_ch.mark_value <= mark;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
  endtask

  // Hold the request side until every expected word is back
  task automatic drain();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_cnt != 0);
  endtask

  // Both region registers, back to back; called only while idle
  task automatic set_region(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_REGION_BEGIN;
    cfg_ch.data  <= lo;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    cfg_ch.index <= CFG_REGION_END;
    cfg_ch.data  <= hi;
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  // One random request; mostly allocations that fit the region and
  // restores of pointers seen earlier, the rest noise
  task automatic random_word(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    int unsigned       pick;
    int unsigned       span;
    logic [DATA_W-1:0] mark;
    span = (hi > lo) ? hi - lo : 32'h100;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_word(OP_ALLOC, $urandom_range(1, 4), $urandom_range(0, span / 16),
                $urandom_range(0, 6), $urandom);
    end else if (pick < 55) begin
      // split: a single item
      send_word(OP_ALLOC, 1, $urandom_range(0, span / 4), $urandom_range(0, 12), $urandom);
    end else if (pick < 63) begin
      if ($urandom_range(0, 1) == 0)
        send_word(OP_ALLOC, $urandom, $urandom, $urandom_range(0, 31), $urandom);
      else
        send_word(OP_ALLOC, $urandom_range(0, 32'hFFFF), $urandom_range(0, 32'hFFFF),
                  $urandom_range(0, 31), $urandom);
    end else if (pick < 78) begin
      mark = (saved_marks.size() == 0) ? hi
             : saved_marks[$urandom_range(0, saved_marks.size() - 1)];
      send_word(OP_RESTORE, $urandom, $urandom, $urandom, mark);
    end else if (pick < 84) begin
      mark = ($urandom_range(0, 1) == 0) ? lo + $urandom_range(0, span) : $urandom;
      send_word(OP_RESTORE, $urandom, $urandom, $urandom, mark);
    end else if (pick < 94) begin
      send_word(OP_RESET, $urandom, $urandom, $urandom, $urandom);
    end else begin
      send_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // Stimulus
  initial begin
    logic [DATA_W-1:0] cur_lo;
    logic [DATA_W-1:0] cur_hi;
    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_ALLOC;
    req_ch.item_count = '0;
    req_ch.item_size  = '0;
    req_ch.align_log2 = '0;
    req_ch.mark_value = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_REGION_BEGIN;
    cfg_ch.data       = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset region: zero-sized allocation hands out address zero
    send_word(OP_ALLOC, 0, 0, 0, 0);
    send_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    drain();

    // pointer still at zero, outside the new region
    set_region(32'h0000_1000, 32'h0002_0000);
    send_word(OP_ALLOC, 1, 32'h10, 0, 0);                   // underflow
    send_word(OP_RESTORE, 0, 0, 0, 32'h0001_0000);          // mark above pointer
    send_word(OP_RESET, 0, 0, 0, 0);
    send_word(OP_ALLOC, 3, 32'h100, 4, 0);
    send_word(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0); // product overflow
    send_word(OP_ALLOC, 32'h0001_0000, 32'h0001_0000, 0, 0); // product just overflows
    send_word(OP_ALLOC, 1, 32'h0002_0000, 0, 0);            // larger than pointer
    send_word(OP_ALLOC, 1, 32'h0001_F000, 0, 0);            // below region begin
    send_word(OP_ALLOC, 0, 32'hFFFF_FFFF, 12, 0);           // align only
    send_word(OP_ALLOC, 1, 1, 31, 0);                       // huge alignment
    send_word(OP_RESTORE, 0, 0, 0, 32'h0001_8000);
    send_word(OP_RESTORE, 0, 0, 0, 32'h0000_1800);          // mark below pointer
    send_word(OP_RESTORE, 0, 0, 0, 32'h0000_0800);          // mark below region
    send_word(OP_RESTORE, 0, 0, 0, 32'h0002_0001);          // mark above region
    send_word(OP_RESTORE, 0, 0, 0, 32'h0002_0000);          // mark at region end
    send_word(OP_ALLOC, 1, 32'h40, 6, 0);                   // split
    send_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'h1F, 32'hFFFF_FFFF);
    drain();

    // full address range
    set_region(32'h0000_0000, 32'hFFFF_FFFF);
    send_word(OP_RESET, 0, 0, 0, 0);
    send_word(OP_ALLOC, 1, 32'hFFFF_FFFF, 0, 0);            // block at zero
    send_word(OP_RESET, 0, 0, 0, 0);
    send_word(OP_ALLOC, 1, 1, 31, 0);
    drain();

    // begin above end
    set_region(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(OP_RESET, 0, 0, 0, 0);
    send_word(OP_RESTORE, 0, 0, 0, 0);

    // random phases, each under its own region
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          cur_lo = 32'h0000_0000;
          cur_hi = 32'hFFFF_FFFF;
        end
        1: begin
          cur_lo = 32'hFFFF_F000;
          cur_hi = 32'hFFFF_FFFF;
        end
        2: begin
          cur_lo = $urandom_range(0, 32'hFFFF_0000);
          cur_hi = cur_lo + $urandom_range(32'h100, 32'h8000);
        end
        3: begin
          cur_hi = $urandom_range(0, 32'h7FFF_FFFF);
          cur_lo = cur_hi + $urandom_range(1, 32'h1000);
        end
        4: begin
          cur_lo = $urandom;
          cur_hi = cur_lo + $urandom_range(16, 32'h0010_0000);
        end
        5: begin
          cur_lo = 32'hFFFF_FFFF;
          cur_hi = 32'hFFFF_FFFF;
        end
        default: begin
          cur_lo = 32'h0000_0000;
          cur_hi = 32'h0000_0800;
        end
      endcase
      drain();
      set_region(cur_lo, cur_hi);
      send_word(OP_RESET, $urandom, $urandom, $urandom, $urandom);
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2) drain();
        random_word(cur_lo, cur_hi);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0)
      $display("downward_bump_allocator_core_tb passed");
    else
      $display("downward_bump_allocator_core_tb failed");
    $finish;
  end

endmodule
